/* src/itf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itf_pkg;

    localparam int GROUP_COUNT         = 8;
    localparam int MIN_COLLAPSE        = 2;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [6:0] CHAR_COLON = 7'h3A;

    typedef struct packed {
        logic [63:0] address_high;
        logic [63:0] address_low;
    } itf_in_t;

    typedef struct packed {
        logic [6:0] text_char;
        logic       is_last;
    } itf_out_t;

    // classified address handed from front to back
    typedef struct packed {
        logic [127:0] addr;
        logic         coll;
        logic [2:0]   gap_start;
        logic [3:0]   run_len;
    } itf_job_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_DIGIT,
        PH_DC2
    } itf_phase_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10)
        begin
            c = 7'h30 + {3'b000, nib};
        end
        else
        begin
            c = 7'h57 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/itf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module itf_front
    import itf_pkg::*;
(
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire itf_in_t  in_data,
    input  wire logic     q_full,
    output logic          push,
    output itf_job_t      job
);

    logic [127:0] addr;
    logic [7:0]   zero;

    assign addr     = {in_data.address_high, in_data.address_low};
    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            zero[i] = (addr[127 - 16 * i -: 16] == 16'h0000);
        end
    end

    // longest zero run, leftmost wins a tie
    always_comb
    begin
        logic [3:0] run;
        logic [3:0] best;
        logic [2:0] rstart;
        logic [2:0] bstart;
        run    = 4'd0;
        best   = 4'd0;
        rstart = 3'd0;
        bstart = 3'd0;
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            if (zero[i])
            begin
                if (run == 4'd0)
                begin
                    rstart = 3'(i);
                end
                run = run + 4'd1;
                if (run > best)
                begin
                    best   = run;
                    bstart = rstart;
                end
            end
            else
            begin
                run = 4'd0;
            end
        end
        job.addr      = addr;
        job.coll      = (best >= 4'(MIN_COLLAPSE));
        job.gap_start = bstart;
        job.run_len   = best;
    end

endmodule

`default_nettype wire

/* src/itf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module itf_queue
    import itf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire itf_job_t push_data,
    output logic          full,
    input  wire logic     pop,
    output itf_job_t      head,
    output logic          head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    itf_job_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* src/itf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module itf_back
    import itf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire itf_job_t job,
    input  wire logic     job_valid,
    output logic          job_pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output itf_out_t      out_data
);

    itf_phase_t phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic [1:0] nib_reg, nib_next;
    logic       nosep_reg, nosep_next;
    logic       out_valid_reg, out_valid_next;
    itf_out_t   out_data_reg;

    logic [15:0] grp [8];
    logic [15:0] g;
    logic [1:0]  lead;
    logic [1:0]  sel;
    logic [3:0]  end_idx;
    logic        advance;
    logic        group_done;
    itf_out_t    ch;

    always_comb
    begin
        for (int i = 0; i < GROUP_COUNT; i++)
        begin
            grp[i] = job.addr[127 - 16 * i -: 16];
        end
    end

    assign g       = grp[idx_reg];
    assign lead    = (g[15:12] != 4'h0) ? 2'd3 :
                     (g[11:8]  != 4'h0) ? 2'd2 :
                     (g[7:4]   != 4'h0) ? 2'd1 : 2'd0;
    assign end_idx = {1'b0, job.gap_start} + job.run_len;
    assign advance = job_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        nib_next     = nib_reg;
        nosep_next   = nosep_reg;
        ch.text_char = CHAR_COLON;
        ch.is_last   = 1'b0;
        group_done   = 1'b0;
        sel          = nib_reg;
        unique case (phase_reg)
            PH_START:
            begin
                sel = lead;
                if (job.coll && idx_reg == job.gap_start)
                begin
                    phase_next = PH_DC2;
                end
                else if (!nosep_reg)
                begin
                    nib_next   = lead;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    // first group, or right after the double colon
                    ch.text_char = hex_char(g[{sel, 2'b00} +: 4]);
                    if (lead == 2'd0)
                    begin
                        group_done = 1'b1;
                    end
                    else
                    begin
                        nib_next   = lead - 2'd1;
                        phase_next = PH_DIGIT;
                    end
                end
            end
            PH_DIGIT:
            begin
                ch.text_char = hex_char(g[{sel, 2'b00} +: 4]);
                if (nib_reg == 2'd0)
                begin
                    group_done = 1'b1;
                end
                else
                begin
                    nib_next = nib_reg - 2'd1;
                end
            end
            PH_DC2:
            begin
                if (end_idx[3])
                begin
                    ch.is_last = 1'b1;
                end
                else
                begin
                    idx_next   = end_idx[2:0];
                    nosep_next = 1'b1;
                    phase_next = PH_START;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
        if (group_done)
        begin
            if (idx_reg == 3'd7)
            begin
                ch.is_last = 1'b1;
            end
            else
            begin
                idx_next   = idx_reg + 3'd1;
                nosep_next = 1'b0;
                phase_next = PH_START;
            end
        end
        if (ch.is_last)
        begin
            phase_next = PH_START;
            idx_next   = 3'd0;
            nosep_next = 1'b1;
        end
    end

    assign job_pop = advance && ch.is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            idx_reg       <= 3'd0;
            nib_reg       <= 2'd0;
            nosep_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                nib_reg   <= nib_next;
                nosep_reg <= nosep_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= ch;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (out_valid && out_data.is_last))
        else $error("request retired without a last character");

    a_dc2_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DC2) |-> (job_valid && job.coll))
        else $error("double colon without a collapsible run");

    a_digit_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGIT) |-> job_valid)
        else $error("emitter mid-group with no request at the head");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (phase_reg == PH_START && idx_reg == 3'd0 && nosep_reg))
        else $error("emitter not rewound after a request");

endmodule

`default_nettype wire

/* src/ipv6_text_formatter_unit.sv */
// Turns each 128-bit IPv6 address into its canonical lower-case text, one ASCII
// character per output transfer, with is_last on the final character. The front
// classifies an address in the cycle it is accepted (longest zero run, leftmost on
// a tie) and drops it into a small queue, so new addresses are taken while the
// previous text is still streaming out. The character emitter at the back produces
// one character per cycle while out_ready does not stall it, so an address holds it
// as long as its text lasts, 2 characters for "::" up to 39 for eight four-digit
// groups; that emitter sets the sustained rate. With the queue empty, an accepted
// address is queued, then its first character is registered at the emitter output.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_text_formatter_unit
    import itf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire itf_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output itf_out_t      out_data
);

    itf_job_t push_job;
    itf_job_t head_job;
    logic     push;
    logic     q_full;
    logic     head_valid;
    logic     job_pop;

    itf_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    itf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_job),
        .full       (q_full),
        .pop        (job_pop),
        .head       (head_job),
        .head_valid (head_valid)
    );

    itf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
